/* hw/rtl/pba_pkg.sv */
`timescale 1ns / 1ps

package pba_pkg;

   localparam int MAX_PAGES     = 65536;
   localparam int MAP_WORD_BITS = 32;
   localparam int PAGE_BYTES    = 4096;

   localparam int MAP_DEPTH  = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_IDX_W = $clog2(MAP_DEPTH);
   localparam int BIT_IDX_W  = $clog2(MAP_WORD_BITS);
   localparam int PAGE_IDX_W = WORD_IDX_W + BIT_IDX_W;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   localparam int ADDR_W   = 32;
   localparam int CFG_W    = 17;
   localparam int COUNT_W  = 17;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

   typedef logic [MAP_WORD_BITS-1:0] map_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic                 found;
      logic [BIT_IDX_W-1:0] index;
   } zero_search_type;

   // Lowest clear bit of a map word.
   function automatic zero_search_type find_lowest_zero(input map_word_type word);
      zero_search_type result;
      result.found = 1'b0;
      result.index = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            result.found = 1'b1;
            result.index = BIT_IDX_W'(i);
         end
      end
      return result;
   endfunction

endpackage

/* hw/rtl/pba_req_if.sv */
`timescale 1ns / 1ps

interface pba_req_if;
   import pba_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [ADDR_W-1:0] page_address;

   modport source (output valid, output opcode, output page_address, input ready);
   modport sink (input valid, input opcode, input page_address, output ready);
endinterface

/* hw/rtl/pba_rsp_if.sv */
`timescale 1ns / 1ps

interface pba_rsp_if;
   import pba_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   granted_address;
   logic [COUNT_W-1:0]  used_count;

   modport source (output valid, output status, output granted_address,
                   output used_count, input ready);
   modport sink (input valid, input status, input granted_address,
                 input used_count, output ready);
endinterface

/* hw/rtl/page_bitmap_allocator.sv */
`timescale 1ns / 1ps
// Out-of-range and unused requests, and allocate with no pages managed, give the result
// word in the cycle after the request is taken; free and mark-used first pass through
// ST_UPDATE; allocate tests map words in ST_SCAN (one per cycle, up to 2048).
// One request at a time: the next is taken in the cycle after the result word is accepted.
// After reset all 2048 map words are cleared; no request is taken meanwhile.
module page_bitmap_allocator (
   input  logic                       clock,
   input  logic                       reset,
   pba_req_if.sink                    req_port,
   pba_rsp_if.source                  rsp_port,
   input  logic                       csr_write_enable,
   input  logic [pba_pkg::CFG_W-1:0]  csr_write_data
);
   import pba_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   state_type                 state_ff, state_in;
   logic [WORD_IDX_W-1:0]     clr_ff, clr_in;
   logic [WORD_IDX_W-1:0]     issue_ff, issue_in;
   logic                      issue_done_ff, issue_done_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [WORD_IDX_W-1:0]     pend_word_ff, pend_word_in;
   logic [OP_W-1:0]           op_ff, op_in;
   logic [PAGE_IDX_W-1:0]     page_ff, page_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic [ADDR_W-1:0]         grant_ff, grant_in;
   logic [CFG_W-1:0]          page_count_ff, page_count_in;

   map_word_type              map_mem [MAP_DEPTH];
   map_word_type              rd_data_ff;
   logic [WORD_IDX_W-1:0]     mem_rd_addr;
   logic                      mem_wr_en;
   logic [WORD_IDX_W-1:0]     mem_wr_addr;
   map_word_type              mem_wr_data;

   logic [CFG_W-1:0]          limit;
   logic [CFG_W-1:0]          limit_m1;
   logic [WORD_IDX_W-1:0]     last_word;
   logic [BIT_IDX_W-1:0]      tail;
   map_word_type              tail_mask;
   map_word_type              test_word;
   zero_search_type           search;
   logic [ADDR_W-1:0]         req_page;
   logic                      cur_bit;
   map_word_type              bit_onehot;

   assign limit     = (32'(page_count_ff) > 32'(MAX_PAGES)) ? CFG_W'(MAX_PAGES) : page_count_ff;
   assign limit_m1  = limit - CFG_W'(1);
   assign last_word = WORD_IDX_W'(limit_m1 >> BIT_IDX_W);
   assign tail      = limit[BIT_IDX_W-1:0];
   assign tail_mask = (tail == '0) ? '0 : ~((map_word_type'(1) << tail) - map_word_type'(1));
   assign test_word = rd_data_ff | ((pend_word_ff == last_word) ? tail_mask : '0);
   assign search    = find_lowest_zero(test_word);
   assign req_page  = req_port.page_address >> PAGE_SHIFT;
   assign cur_bit   = rd_data_ff[page_ff[BIT_IDX_W-1:0]];
   assign bit_onehot = map_word_type'(1) << page_ff[BIT_IDX_W-1:0];

   assign page_count_in = csr_write_enable ? csr_write_data : page_count_ff;

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      issue_in        = issue_ff;
      issue_done_in   = issue_done_ff;
      pend_valid_in   = 1'b0;
      pend_word_in    = pend_word_ff;
      op_in           = op_ff;
      page_in         = page_ff;
      count_in        = count_ff;
      status_in       = status_ff;
      grant_in        = grant_ff;
      mem_rd_addr     = issue_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = page_ff[PAGE_IDX_W-1:BIT_IDX_W];
      mem_wr_data     = rd_data_ff;
      req_port.ready  = 1'b0;
      rsp_port.valid  = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + WORD_IDX_W'(1);
            if (clr_ff == WORD_IDX_W'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_port.ready = 1'b1;
            mem_rd_addr    = req_page[PAGE_IDX_W-1:BIT_IDX_W];
            if (req_port.valid) begin
               op_in     = req_port.opcode;
               page_in   = req_page[PAGE_IDX_W-1:0];
               status_in = STATUS_OK;
               grant_in  = '0;
               case (req_port.opcode) inside
                  OP_ALLOC: begin
                     if (limit == '0) begin
                        status_in = STATUS_NO_FREE;
                        state_in  = ST_RESPOND;
                     end else begin
                        issue_in      = '0;
                        issue_done_in = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
                  OP_FREE, OP_MARK: begin
                     if (req_page >= ADDR_W'(limit)) begin
                        status_in = STATUS_RANGE;
                        state_in  = ST_RESPOND;
                     end else begin
                        state_in = ST_UPDATE;
                     end
                  end
                  default: begin
                     state_in = ST_RESPOND;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!issue_done_ff) begin
               pend_valid_in = 1'b1;
               pend_word_in  = issue_ff;
               if (issue_ff == last_word) begin
                  issue_done_in = 1'b1;
               end else begin
                  issue_in = issue_ff + WORD_IDX_W'(1);
               end
            end
            if (pend_valid_ff) begin
               if (search.found) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = pend_word_ff;
                  mem_wr_data = rd_data_ff | (map_word_type'(1) << search.index);
                  count_in    = (count_ff < COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
                  grant_in    = ADDR_W'(ADDR_W'({pend_word_ff, search.index}) << PAGE_SHIFT);
                  status_in   = STATUS_OK;
                  state_in    = ST_RESPOND;
               end else if (pend_word_ff == last_word) begin
                  status_in = STATUS_NO_FREE;
                  state_in  = ST_RESPOND;
               end
            end
         end
         ST_UPDATE: begin
            if (op_ff == OP_FREE) begin
               if (cur_bit) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = rd_data_ff & ~bit_onehot;
                  count_in    = (count_ff > '0) ? count_ff - COUNT_W'(1) : count_ff;
               end
            end else begin
               if (!cur_bit) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = rd_data_ff | bit_onehot;
                  count_in    = (count_ff < COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
               end
            end
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_port.valid = 1'b1;
            if (rsp_port.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_port.status          = status_ff;
   assign rsp_port.granted_address = grant_ff;
   assign rsp_port.used_count      = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         issue_done_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         page_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         issue_done_ff <= issue_done_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         page_count_ff <= page_count_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      pend_word_ff <= pend_word_in;
      op_ff        <= op_in;
      page_ff      <= page_in;
      status_ff    <= status_in;
      grant_ff     <= grant_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         map_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= map_mem[mem_rd_addr];
   end

   assert property (@(posedge clock) disable iff (reset)
      !(req_port.ready && rsp_port.valid))
      else $error("request taken while a result word is pending");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.status != STATUS_OK) |-> rsp_port.granted_address == '0)
      else $error("granted address set on a failed request");

   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_PAGES))
      else $error("used page count exceeds the map size");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESPOND) |-> !mem_wr_en)
      else $error("map written outside a request");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> state_ff == ST_RESPOND)
      else $error("page update did not finish in one cycle");

endmodule
